>>> design/skf_pkg.sv
// Shared types and constants of the scalar Kalman smoother.
package skf_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegSafetyScore = 3'd0;
  localparam logic [RegIdxW-1:0] RegProcNoise   = 3'd1;
  localparam logic [RegIdxW-1:0] RegMeasNoise   = 3'd2;
  localparam logic [RegIdxW-1:0] RegInitCov     = 3'd3;
  localparam logic [RegIdxW-1:0] RegWarmupCount = 3'd4;

  localparam logic signed [31:0] SafetyScoreRst = 32'sd0;
  localparam logic [31:0]        ProcNoiseRst   = 32'd1073742;
  localparam logic [31:0]        MeasNoiseRst   = 32'd10737418;
  localparam logic [31:0]        InitCovRst     = 32'd1073741824;
  localparam logic [7:0]         WarmupRst      = 8'd10;

  // 1.0 and 0.5 in Q1.30.
  localparam logic [30:0] OneQ30  = 31'h4000_0000;
  localparam logic [30:0] HalfQ30 = 31'h2000_0000;

  typedef struct packed {
    logic signed [31:0] fallback_score;
    logic [31:0]        process_noise;
    logic [31:0]        measurement_noise;
    logic [31:0]        initial_error_cov;
    logic [7:0]         warmup_count;
  } skf_cfg_t;

  typedef struct packed {
    logic        ld_estimate;
    logic        ld_cov;
    logic [31:0] value;
  } skf_load_t;

  typedef struct packed {
    logic capture;
    logic predict;
    logic div_step;
    logic mul;
    logic update;
    logic emit;
  } skf_cmd_t;

  typedef struct packed {
    logic out_free;
  } skf_status_t;

endpackage

>>> design/skf_if.sv
// Request channel interfaces for scores in and smoothed results out.
interface skf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] score;
  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

interface skf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] smoothed;
  logic               warming_up;
  modport source (output valid, output smoothed, output warming_up, input ready);
  modport sink   (input valid, input smoothed, input warming_up, output ready);
endinterface

>>> design/scalar_kalman_smoother_top.sv
// Top level of the scalar Kalman smoother: register file, sequencer and datapath.
//
// Scores (signed Q16.16) arrive as requests on in_ch and each yields exactly one
// request on out_ch carrying the smoothed estimate, or the safety score with
// warming_up set for the first warmup_count items after reset. The filter state is
// updated for every item, warm-up or not.
//
// One item is worked on at a time. After acceptance the item goes through the predict
// step, the restoring divider that forms the gain (one quotient bit per cycle), the
// multiply step, the update step and the load of the result register, which waits
// until the result register is free; only then can a new score be accepted.
//
// The result register parts the two sides: a stalled receiver holds the result
// steady, and the next score is still accepted and processed; it then waits in
// the final step until the result register frees up.
//
// Reset (rst_ni low, asynchronous) restores the register defaults, sets the
// estimate to the safety score and the covariance to its initial value, and clears
// the warm-up count. The user must write registers over the APB-style port while idle;
// it is not enforced. A safety-score or initial-covariance write reloads that state.
module scalar_kalman_smoother_top
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  skf_in_if.sink           in_ch,
  skf_out_if.source        out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  skf_cfg_t    cfg;
  skf_load_t   load;
  skf_cmd_t    cmd;
  skf_status_t status;
  logic        in_ready;

  skf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .load_o  (load)
  );

  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  skf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .load_i       (load),
    .score_i      (in_ch.score),
    .out_ready_i  (out_ch.ready),
    .status_o     (status),
    .out_valid_o  (out_ch.valid),
    .smoothed_o   (out_ch.smoothed),
    .warming_up_o (out_ch.warming_up)
  );

  assign in_ch.ready = in_ready;

endmodule

>>> design/skf_regs.sv
// APB-style configuration register file of the smoother.
module skf_regs
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output skf_cfg_t         cfg_o,
  output skf_load_t        load_o
);

  skf_cfg_t           cfg_q, cfg_d;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegSafetyScore: cfg_d.fallback_score    = $signed(pwdata);
        RegProcNoise:   cfg_d.process_noise     = pwdata;
        RegMeasNoise:   cfg_d.measurement_noise = pwdata;
        RegInitCov:     cfg_d.initial_error_cov = pwdata;
        RegWarmupCount: cfg_d.warmup_count      = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fallback_score    <= SafetyScoreRst;
      cfg_q.process_noise     <= ProcNoiseRst;
      cfg_q.measurement_noise <= MeasNoiseRst;
      cfg_q.initial_error_cov <= InitCovRst;
      cfg_q.warmup_count      <= WarmupRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      RegSafetyScore: prdata = cfg_q.fallback_score;
      RegProcNoise:   prdata = cfg_q.process_noise;
      RegMeasNoise:   prdata = cfg_q.measurement_noise;
      RegInitCov:     prdata = cfg_q.initial_error_cov;
      RegWarmupCount: prdata = {24'd0, cfg_q.warmup_count};
      default:        prdata = '0;
    endcase
  end

  // Writes to the initial values also reload the filter state.
  assign load_o.ld_estimate = wr_en && (idx == RegSafetyScore);
  assign load_o.ld_cov      = wr_en && (idx == RegInitCov);
  assign load_o.value       = pwdata;
  assign cfg_o              = cfg_q;

endmodule

>>> design/skf_dp.sv
// Datapath of the smoother: filter state, gain divider, multipliers, result register.
module skf_dp
  import skf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skf_cmd_t           cmd_i,
  input  skf_cfg_t           cfg_i,
  input  skf_load_t          load_i,
  input  logic signed [31:0] score_i,
  input  logic               out_ready_i,
  output skf_status_t        status_o,
  output logic               out_valid_o,
  output logic signed [31:0] smoothed_o,
  output logic               warming_up_o
);

  // Filter state.
  logic signed [31:0] estimate_q, estimate_d;
  logic [31:0]        cov_q, cov_d;
  logic [7:0]         seen_q, seen_d;

  // Per-item working registers.
  logic signed [31:0] y_q;
  logic               warm_q;
  logic [31:0]        p_q;
  logic [32:0]        denom_q;
  logic [33:0]        rem_q;
  logic [30:0]        quo_q;
  logic signed [63:0] prod_e_q;
  logic [62:0]        prod_p_q;

  // Result register.
  logic               out_valid_q;
  logic signed [31:0] smoothed_q;
  logic               warming_q;

  logic [32:0]        p_sum;
  logic [31:0]        p_sat;
  logic [33:0]        rem_sub;
  logic               q_bit;
  logic [30:0]        gain;
  logic signed [32:0] diff;
  logic signed [31:0] gain_s;
  logic signed [64:0] mult_e;
  logic [30:0]        one_minus_k;
  logic [62:0]        mult_p;
  logic signed [63:0] biased;
  logic signed [33:0] corr;
  logic signed [34:0] x_sum;
  logic signed [31:0] x_sat;
  logic [62:0]        p_round;
  logic [32:0]        p_new;
  logic [31:0]        p_new_sat;

  // Predict with saturation.
  assign p_sum = {1'b0, cov_q} + {1'b0, cfg_i.process_noise};
  assign p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];

  // One restoring division step of the gain P*2^30/(P+R).
  assign q_bit   = (rem_q >= {1'b0, denom_q});
  assign rem_sub = q_bit ? (rem_q - {1'b0, denom_q}) : rem_q;

  assign gain        = (denom_q == 33'd0) ? 31'd0 : quo_q;
  assign diff        = $signed({y_q[31], y_q}) - $signed({estimate_q[31], estimate_q});
  assign gain_s      = $signed({1'b0, gain});
  assign mult_e      = diff * gain_s;
  assign one_minus_k = OneQ30 - gain;
  assign mult_p      = one_minus_k * p_q;

  // Round half up, then add to the estimate with saturation.
  assign biased = prod_e_q + $signed({33'd0, HalfQ30});
  assign corr   = biased[63:30];
  assign x_sum  = $signed({{3{estimate_q[31]}}, estimate_q}) + $signed({corr[33], corr});
  always_comb begin
    if (x_sum > $signed(35'sh0_7FFF_FFFF)) begin
      x_sat = 32'sh7FFF_FFFF;
    end else if (x_sum < -$signed(35'sh0_8000_0000)) begin
      x_sat = -32'sh8000_0000;
    end else begin
      x_sat = x_sum[31:0];
    end
  end

  // Covariance update rounds half up at the 2^30 divide.
  assign p_round   = prod_p_q + {32'd0, HalfQ30};
  assign p_new     = p_round[62:30];
  assign p_new_sat = p_new[32] ? 32'hFFFF_FFFF : p_new[31:0];

  always_comb begin
    estimate_d = estimate_q;
    cov_d      = cov_q;
    seen_d     = seen_q;
    if (load_i.ld_estimate) begin
      estimate_d = $signed(load_i.value);
    end
    if (load_i.ld_cov) begin
      cov_d = load_i.value;
    end
    if (cmd_i.capture && (seen_q < cfg_i.warmup_count)) begin
      seen_d = seen_q + 8'd1;
    end
    if (cmd_i.update) begin
      estimate_d = x_sat;
      cov_d      = p_new_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estimate_q  <= SafetyScoreRst;
      cov_q       <= InitCovRst;
      seen_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      estimate_q <= estimate_d;
      cov_q      <= cov_d;
      seen_q     <= seen_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      y_q    <= score_i;
      warm_q <= (seen_q < cfg_i.warmup_count);
    end
    if (cmd_i.predict) begin
      p_q     <= p_sat;
      denom_q <= {1'b0, p_sat} + {1'b0, cfg_i.measurement_noise};
      rem_q   <= {2'b00, p_sat};
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= {rem_sub[32:0], 1'b0};
      quo_q <= {quo_q[29:0], q_bit};
    end
    if (cmd_i.mul) begin
      prod_e_q <= $signed(mult_e[63:0]);
      prod_p_q <= mult_p;
    end
    if (cmd_i.emit) begin
      smoothed_q <= warm_q ? cfg_i.fallback_score : estimate_q;
      warming_q  <= warm_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign smoothed_o        = smoothed_q;
  assign warming_up_o      = warming_q;

endmodule

>>> design/skf_ctrl.sv
// Smoother sequencer: steps one item through predict, divide, multiply, update and emit.
module skf_ctrl
  import skf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  skf_status_t status_i,
  output skf_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPred = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StHold = 3'd5;

  // The gain has 31 quotient bits, one per divide cycle.
  localparam logic [4:0] DivLast = 5'd30;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StPred;
        end
      end
      StPred: begin
        cmd_o.predict = 1'b1;
        cnt_d         = '0;
        state_d       = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivLast) begin
          state_d = StMul;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StUpd;
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d      = StHold;
      end
      StHold: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> dv/scalar_kalman_smoother_top_tb.sv
// Self-checking testbench for the scalar Kalman smoother: predictor, driver and monitor.
module scalar_kalman_smoother_top_tb
  import skf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] smoothed;
    logic               warming_up;
  } smooth_result_t;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam int unsigned ItemsPerSetting = 125;
  localparam int unsigned RandomSettings  = 14;

  logic clk_i;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  skf_in_if  in_ch ();
  skf_out_if out_ch ();

  scalar_kalman_smoother_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scores waiting to be sent, and the results the filter mirror expects back.
  logic [31:0]    pending_scores[$];
  smooth_result_t expected_results[$];

  // Mirror of the register file and of the filter state.
  skf_cfg_t           cfg_q;
  logic signed [31:0] est_q;
  logic [31:0]        cov_q;
  logic [7:0]         seen_q;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        score_taken;

  int unsigned mismatches;
  int unsigned scores_in;
  int unsigned results_out;
  int unsigned warmup_results;
  int unsigned gain_zero_hits;
  int unsigned gain_one_hits;
  int unsigned settings_used;

  initial begin
    clk_i         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.score   = '0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    forever #10 clk_i = ~clk_i;
  end

  // One Kalman step on the mirrored state: predict, gain, estimate and covariance
  // update, then the warm-up decision on what goes out.
  function automatic smooth_result_t smooth_score(input logic signed [31:0] y);
    longint         p;
    longint         denom;
    longint         gain;
    longint         diff;
    longint         corr;
    longint         x;
    longint         newp;
    smooth_result_t r;
    p = cov_q;
    p += cfg_q.process_noise;
    if (p > 64'sh0_FFFF_FFFF) p = 64'sh0_FFFF_FFFF;
    denom = p + cfg_q.measurement_noise;
    gain = (denom == 0) ? 0 : (p << 30) / denom;
    if (gain > longint'(OneQ30)) gain = longint'(OneQ30);
    if (gain == 0) gain_zero_hits++;
    if (gain == longint'(OneQ30)) gain_one_hits++;
    // The correction is exact before the divide by 2^30, which rounds half up.
    diff = y;
    diff -= est_q;
    corr = (diff * gain + longint'(HalfQ30)) >>> 30;
    x = est_q;
    x += corr;
    if (x > S32Max) x = S32Max;
    if (x < S32Min) x = S32Min;
    est_q = x[31:0];
    newp = ((longint'(OneQ30) - gain) * p + longint'(HalfQ30)) >> 30;
    if (newp > 64'sh0_FFFF_FFFF) newp = 64'sh0_FFFF_FFFF;
    cov_q = newp[31:0];
    // The warm-up counter stops at warmup_count, so it cannot wrap.
    if (seen_q < cfg_q.warmup_count) begin
      seen_q++;
      r = '{cfg_q.fallback_score, 1'b1};
    end else begin
      r = '{est_q, 1'b0};
    end
    return r;
  endfunction

  // Sender: a new score goes out only once the previous one has been taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || score_taken) begin
      if (pending_scores.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.score <= pending_scores.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: accepted scores feed the mirror, accepted results are checked in order.
  always @(posedge clk_i) begin
    smooth_result_t want;
    if (!rst_ni) begin
      score_taken <= 1'b0;
    end else begin
      score_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        results_out++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: smoothed %h, warming_up %b",
                 out_ch.smoothed, out_ch.warming_up);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.warming_up) warmup_results++;
          if (out_ch.smoothed !== want.smoothed) begin
            $error("smoothed: expected %h, actual %h", want.smoothed, out_ch.smoothed);
            mismatches++;
          end
          if (out_ch.warming_up !== want.warming_up) begin
            $error("warming_up: expected %b, actual %b", want.warming_up,
                   out_ch.warming_up);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        scores_in++;
        expected_results.push_back(smooth_score(in_ch.score));
      end
    end
  end

  // Register write over the APB-style port. The mirror follows the write, and the
  // two state-loading registers also reload the estimate and the covariance.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegSafetyScore: begin
        cfg_q.fallback_score = value;
        est_q                = value;
      end
      RegProcNoise:   cfg_q.process_noise = value;
      RegMeasNoise:   cfg_q.measurement_noise = value;
      RegInitCov: begin
        cfg_q.initial_error_cov = value;
        cov_q                   = value;
      end
      RegWarmupCount: cfg_q.warmup_count = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("register %0d: expected %h, actual %h", idx, want, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_all_regs();
    check_reg(RegSafetyScore, cfg_q.fallback_score);
    check_reg(RegProcNoise, cfg_q.process_noise);
    check_reg(RegMeasNoise, cfg_q.measurement_noise);
    check_reg(RegInitCov, cfg_q.initial_error_cov);
    check_reg(RegWarmupCount, {24'd0, cfg_q.warmup_count});
  endtask

  // Waits until every score has been taken and every result has come back.
  task automatic wait_drained();
    while (pending_scores.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_extreme_score();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Mostly a noisy signal around a level, with wild samples and extremes mixed in.
  function automatic logic [31:0] pick_score(input logic [31:0] level);
    int unsigned sel;
    logic [31:0] noise;
    sel   = $urandom_range(99);
    noise = $urandom_range(32'h7_FFFF) - 32'h4_0000;
    if (sel < 60) return level + noise;
    if (sel < 80) return $urandom();
    if (sel < 90) return pick_extreme_score();
    return $urandom_range(511) - 256;
  endfunction

  function automatic logic [31:0] pick_cov();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(32'h00FF_FFFF);
      3:       return $urandom_range(32'h4000_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_warmup();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'd255;
      2:       return $urandom_range(20, 1);
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic run_random_setting(input int unsigned count);
    logic [31:0] level;
    if ($urandom_range(1)) begin
      write_reg(RegSafetyScore, $urandom_range(1) ? pick_extreme_score() : $urandom());
    end
    write_reg(RegProcNoise, pick_cov());
    write_reg(RegMeasNoise, pick_cov());
    if ($urandom_range(1)) write_reg(RegInitCov, pick_cov());
    write_reg(RegWarmupCount, pick_warmup());
    check_all_regs();
    settings_used++;
    level = $urandom();
    for (int unsigned i = 0; i < count; i++) begin
      // Now and then the measured signal jumps to a new level.
      if ($urandom_range(19) == 0) level = $urandom();
      pending_scores.push_back(pick_score(level));
    end
    wait_drained();
  endtask

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    mismatches     = 0;
    scores_in      = 0;
    results_out    = 0;
    warmup_results = 0;
    gain_zero_hits = 0;
    gain_one_hits  = 0;
    settings_used  = 1;
    tx_idle_pct    = 28;
    rx_idle_pct    = 84;
    cfg_q  = '{SafetyScoreRst, ProcNoiseRst, MeasNoiseRst, InitCovRst, WarmupRst};
    est_q  = SafetyScoreRst;
    cov_q  = InitCovRst;
    seen_q = '0;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values, then the warm-up boundary and score extremes on defaults.
    check_all_regs();
    pending_scores = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                       32'hFFFF_0000, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF};
    wait_drained();

    // Writes beyond the register list must leave everything alone.
    for (int i = int'(RegWarmupCount) + 1; i < 2 ** RegIdxW; i++) begin
      write_reg(i[RegIdxW-1:0], $urandom());
    end
    check_all_regs();

    // Saturated predict: P + Q overflows, and the warm-up is switched off.
    write_reg(RegSafetyScore, 32'h7FFF_FFFF);
    write_reg(RegProcNoise, 32'hFFFF_FFFF);
    write_reg(RegMeasNoise, 32'hFFFF_FFFF);
    write_reg(RegInitCov, 32'hFFFF_FFFF);
    write_reg(RegWarmupCount, 32'd0);
    settings_used++;
    pending_scores = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
    wait_drained();

    // Zero denominator: P, Q and R all zero give a gain of zero.
    write_reg(RegSafetyScore, 32'h8000_0000);
    write_reg(RegProcNoise, 32'd0);
    write_reg(RegMeasNoise, 32'd0);
    write_reg(RegInitCov, 32'd0);
    settings_used++;
    pending_scores = '{32'h7FFF_FFFF, 32'h0000_1234, 32'h8000_0000};
    wait_drained();

    // Unity gain: with P at one and R at zero the estimate takes the first score as it is.
    write_reg(RegInitCov, 32'd1);
    settings_used++;
    pending_scores = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
    wait_drained();

    // Random settings. Each one starts with the sender held back until every
    // result of the previous one has come home.
    for (int unsigned s = 0; s < RandomSettings; s++) begin
      if (s == 5) begin
        tx_idle_pct = 84;
        rx_idle_pct = 28;
      end else if (s == 10) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_random_setting(ItemsPerSetting);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d scores over %0d register settings; %0d results came back,",
             scores_in, settings_used, results_out);
    $display("%0d of them in warm-up; the gain was zero %0d times and unity %0d times.",
             warmup_results, gain_zero_hits, gain_one_hits);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/skf_pkg.sv
design/skf_if.sv
design/skf_regs.sv
design/skf_dp.sv
design/skf_ctrl.sv
design/scalar_kalman_smoother_top.sv
dv/scalar_kalman_smoother_top_tb.sv
